[hdl/bsz_pkg.sv]
// ----------------------------------------------------------------------------
// bsz_pkg
// Shared types and constants of the bearing smoother and zone indicator.
// ----------------------------------------------------------------------------
package bsz_pkg;

	// fixed point scaling of angles (degrees times 2^ANGLE_FRAC_BITS)
	localparam int ANGLE_FRAC_BITS = 4;

	// field widths
	localparam int ANGLE_W = 13;
	localparam int ZONE_W  = 2;
	localparam int BLINK_W = 17;
	localparam int TONE_W  = 10;
	localparam int CFG_IDX_W = 2;

	// wide work width for the wrap arithmetic, holds 2*8191 + 360*16
	localparam int WORK_W = 18;

	localparam logic [WORK_W-1:0] FULL_TURN  = WORK_W'(360 << ANGLE_FRAC_BITS);
	localparam logic [WORK_W-1:0] NEAR_NORTH = WORK_W'(10 << ANGLE_FRAC_BITS);
	localparam logic [WORK_W-1:0] HIGH_NORTH = FULL_TURN - NEAR_NORTH;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 2'd3;

	// register reset values
	localparam logic [ANGLE_W-1:0] OUTER_LOW_RST   = 13'd2880;
	localparam logic [ANGLE_W-1:0] OUTER_HIGH_RST  = 13'd3520;
	localparam logic [ANGLE_W-1:0] TARGET_LOW_RST  = 13'd3120;
	localparam logic [ANGLE_W-1:0] TARGET_HIGH_RST = 13'd3280;

	// zone codes
	localparam logic [ZONE_W-1:0] ZONE_OUTSIDE = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_FAR     = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_TARGET  = 2'd2;
	localparam logic [ZONE_W-1:0] ZONE_EDGE    = 2'd3;

	// drive values
	localparam logic [BLINK_W-1:0] BLINK_OUTSIDE  = 17'd1000;
	localparam logic [BLINK_W-1:0] BLINK_TARGET   = 17'd50;
	localparam logic [BLINK_W-1:0] BLINK_FAR_BASE = 17'd50;
	localparam logic [BLINK_W-1:0] BLINK_MAX      = 17'h1FFFF;
	localparam logic [TONE_W-1:0]  FREQ_FAR       = 10'd500;
	localparam logic [TONE_W-1:0]  FREQ_TARGET    = 10'd1000;
	localparam logic [TONE_W-1:0]  DUR_FAR        = 10'd1000;
	localparam logic [TONE_W-1:0]  DUR_TARGET     = 10'd200;

	// led and buzzer drive group
	typedef struct packed {
		logic [BLINK_W-1:0] blink_rate;
		logic               tone_on;
		logic [TONE_W-1:0]  tone_freq;
		logic [TONE_W-1:0]  tone_duration;
	} drive_t;

	// window edges
	typedef struct packed {
		logic [ANGLE_W-1:0] outer_low;
		logic [ANGLE_W-1:0] outer_high;
		logic [ANGLE_W-1:0] target_low;
		logic [ANGLE_W-1:0] target_high;
	} window_t;

endpackage

[hdl/bsz_avg.sv]
// ----------------------------------------------------------------------------
// bsz_avg
// Wrap-aware half-weight average of the stored bearing and a new sample.
// ----------------------------------------------------------------------------
module bsz_avg (
	input  logic [bsz_pkg::ANGLE_W-1:0] cur,
	input  logic [bsz_pkg::ANGLE_W-1:0] raw,
	output logic [bsz_pkg::ANGLE_W-1:0] avg
);
	import bsz_pkg::*;

	logic [WORK_W-1:0] cur_w;
	logic [WORK_W-1:0] raw_w;
	logic              wrap;
	logic [WORK_W-1:0] sum;
	logic [WORK_W-1:0] half;
	logic [WORK_W-1:0] res;

	assign cur_w = WORK_W'(cur);
	assign raw_w = WORK_W'(raw);

	// operands on opposite sides of north
	assign wrap = (cur_w > HIGH_NORTH && raw_w < NEAR_NORTH) ||
		(cur_w < NEAR_NORTH && raw_w > HIGH_NORTH);

	// add a full turn to the low side when wrapping
	assign sum  = wrap ? (cur_w + raw_w + FULL_TURN) : (cur_w + raw_w);
	assign half = sum >> 1;

	// take the turn back off when the halved sum reaches a full turn
	always_comb begin
		if (wrap && half >= FULL_TURN) begin
			res = half - FULL_TURN;
		end else begin
			res = half;
		end
	end

	assign avg = res[ANGLE_W-1:0];

endmodule

[hdl/bsz_zone.sv]
// ----------------------------------------------------------------------------
// bsz_zone
// Classifies a bearing against the windows and builds the drive values.
// ----------------------------------------------------------------------------
module bsz_zone (
	input  logic [bsz_pkg::ANGLE_W-1:0] bearing,
	input  bsz_pkg::window_t            win,
	input  bsz_pkg::drive_t             drv_prev,
	output logic [bsz_pkg::ZONE_W-1:0]  zone,
	output bsz_pkg::drive_t             drv_next
);
	import bsz_pkg::*;

	localparam int PROD_W = 2 * ANGLE_W;

	logic                outside;
	logic                far;
	logic                target;
	logic [ANGLE_W-1:0]  dev;
	logic [ANGLE_W-1:0]  dev_deg;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     blink_sum;
	logic [BLINK_W-1:0]  blink_far;

	// window tests
	assign outside = (bearing < win.outer_low) || (bearing > win.outer_high);
	assign far     = (bearing < win.target_low) || (bearing > win.target_high);
	assign target  = (bearing > win.target_low) && (bearing < win.target_high);

	// distance to the nearer target edge in whole degrees
	assign dev = (bearing < win.target_low) ? (win.target_low - bearing)
		: (bearing - win.target_high);
	assign dev_deg = dev >> ANGLE_FRAC_BITS;

	// squared deviation plus base, saturated
	assign prod      = PROD_W'(dev_deg) * PROD_W'(dev_deg);
	assign blink_sum = {1'b0, prod} + (PROD_W + 1)'(BLINK_FAR_BASE);
	assign blink_far = (blink_sum > (PROD_W + 1)'(BLINK_MAX)) ? BLINK_MAX
		: blink_sum[BLINK_W-1:0];

	// zone decision, in order of precedence
	always_comb begin
		drv_next = drv_prev;
		priority if (outside) begin
			zone                   = ZONE_OUTSIDE;
			drv_next.blink_rate    = BLINK_OUTSIDE;
			drv_next.tone_on       = 1'b0;
			drv_next.tone_freq     = '0;
			drv_next.tone_duration = '0;
		end else if (far) begin
			zone                   = ZONE_FAR;
			drv_next.blink_rate    = blink_far;
			drv_next.tone_on       = 1'b1;
			drv_next.tone_freq     = FREQ_FAR;
			drv_next.tone_duration = DUR_FAR;
		end else if (target) begin
			zone                   = ZONE_TARGET;
			drv_next.blink_rate    = BLINK_TARGET;
			drv_next.tone_on       = 1'b1;
			drv_next.tone_freq     = FREQ_TARGET;
			drv_next.tone_duration = DUR_TARGET;
		end else begin
			// exactly on a target edge: keep previous drive
			zone = ZONE_EDGE;
		end
	end

endmodule

[hdl/bearing_smoother_zone_indicator.sv]
// ----------------------------------------------------------------------------
// bearing_smoother_zone_indicator
// Smooths compass bearings and turns them into LED and buzzer drive values.
// ----------------------------------------------------------------------------
// Usage:
//   Raw bearings (degrees times 16) arrive on the s_axis channel, one per
//   transaction. Each gives exactly one result transaction on m_axis: the
//   smoothed bearing, its zone and the blink and tone drive values.
//   Window edges are set through the cfg_we / cfg_index / cfg_data port,
//   one register per cycle; the user must write them only while no
//   transaction is in flight, as the block does not enforce this.
// Pipeline and throughput:
//   the input register feeds the smoothing and zone logic, which fills the
//   result register. One transaction is taken every cycle unless the output
//   stalls; the smoothed bearing feeds back through a single register.
// Reset:
//   arst_n clears the valid flags of both pipeline stages, the smoothed
//   bearing and the held drive values, and loads the default window edges.
// Stall:
//   while m_axis_tready is low the result is held; the input register still
//   takes one more sample, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
module bearing_smoother_zone_indicator (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,  // bearing_sample[12:0]
	// master stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// filtered_bearing[12:0], zone[14:13], blink_rate[31:15], tone_on[32],
	// tone_freq[42:33], tone_duration[52:43]
	output logic [55:0]                    m_axis_tdata,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [bsz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsz_pkg::ANGLE_W-1:0]    cfg_data
);
	import bsz_pkg::*;

	window_t             win_q;
	logic [ANGLE_W-1:0]  smoothed_q;
	drive_t              drv_q;

	logic                valid_s1;
	logic [ANGLE_W-1:0]  sample_s1;

	logic                valid_s2;
	logic [ANGLE_W-1:0]  bearing_s2;
	logic [ZONE_W-1:0]   zone_s2;
	drive_t              drv_s2;

	logic                adv_s2;
	logic                adv_s1;
	logic [ANGLE_W-1:0]  avg;
	logic [ZONE_W-1:0]   zone;
	drive_t              drv_next;

	// handshake
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.outer_low   <= OUTER_LOW_RST;
			win_q.outer_high  <= OUTER_HIGH_RST;
			win_q.target_low  <= TARGET_LOW_RST;
			win_q.target_high <= TARGET_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUTER_LOW:   win_q.outer_low   <= cfg_data;
				REG_OUTER_HIGH:  win_q.outer_high  <= cfg_data;
				REG_TARGET_LOW:  win_q.target_low  <= cfg_data;
				REG_TARGET_HIGH: win_q.target_high <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata[ANGLE_W-1:0];
		end
	end

	// smoothing and classification
	bsz_avg u_avg (
		.cur (smoothed_q),
		.raw (sample_s1),
		.avg (avg)
	);

	bsz_zone u_zone (
		.bearing  (avg),
		.win      (win_q),
		.drv_prev (drv_q),
		.zone     (zone),
		.drv_next (drv_next)
	);

	// feedback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
			drv_q      <= '0;
		end else if (adv_s1) begin
			smoothed_q <= avg;
			drv_q      <= drv_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			bearing_s2 <= avg;
			zone_s2    <= zone;
			drv_s2     <= drv_next;
		end
	end

	// output packing
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, drv_s2.tone_duration, drv_s2.tone_freq,
		drv_s2.tone_on, drv_s2.blink_rate, zone_s2, bearing_s2};

	// checks
	a_smooth_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (smoothed_q == bearing_s2 && valid_s2))
		else $error("smoothed bearing differs from the delivered result");

	a_outside_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && zone_s2 == ZONE_OUTSIDE) |->
		(drv_s2.blink_rate == BLINK_OUTSIDE && !drv_s2.tone_on))
		else $error("outside zone with wrong drive values");

	a_edge_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && zone == ZONE_EDGE) |=> (drv_q == $past(drv_q)))
		else $error("edge zone changed the held drive values");

	a_far_tone: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && zone_s2 == ZONE_FAR) |->
		(drv_s2.tone_on && drv_s2.tone_freq == FREQ_FAR &&
		drv_s2.blink_rate >= BLINK_FAR_BASE))
		else $error("far zone with wrong drive values");

endmodule
